/* design/cptp_pkg.sv */
// Package: shared types and constants of the control packet TLV parser.
`default_nettype none

package cptp_pkg;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_TYPE    = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_VALUE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SIZE  = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_BADLEN = 2'd2,
    ST_NOSIZE = 2'd3
  } status_t;

  localparam logic [7:0] TYPE_SIZE      = 8'h00;
  localparam logic [7:0] TYPE_NAME      = 8'h01;
  localparam logic [7:0] SIZE_MAX_BYTES = 8'd8;
  localparam logic [7:0] NAME_LIMIT_RST = 8'hFF;

endpackage

`default_nettype wire

/* design/cptp_in_if.sv */
// Interface: input byte channel of the control packet TLV parser.
`default_nettype none

interface cptp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       is_last;

  modport source (output valid, output packet_byte, output is_last, input ready);
  modport sink   (input valid, input packet_byte, input is_last, output ready);
endinterface

`default_nettype wire

/* design/cptp_out_if.sv */
// Interface: result channel of the control packet TLV parser.
`default_nettype none

interface cptp_out_if;
  logic        valid;
  logic        ready;
  logic        name_valid;
  logic [7:0]  name_index;
  logic [7:0]  name_char;
  logic        packet_done;
  logic [63:0] file_size;
  logic [7:0]  name_length;
  logic [1:0]  parse_status;

  modport source (
    output valid, output name_valid, output name_index, output name_char,
    output packet_done, output file_size, output name_length, output parse_status,
    input ready
  );
  modport sink (
    input valid, input name_valid, input name_index, input name_char,
    input packet_done, input file_size, input name_length, input parse_status,
    output ready
  );
endinterface

`default_nettype wire

/* design/control_packet_tlv_parser_unit.sv */
// Top level: control packet TLV parser, one byte per transaction.
//
//   channel  direction  payload                                   handshake
//   in_ch    sink       packet_byte[8], is_last                   valid/ready
//   out_ch   source     name_valid, name_index, name_char,        valid/ready
//                       packet_done, file_size[64], name_length,
//                       parse_status[2]
//   cfg      write      cfg_wdata[8] = name_limit                 cfg_we
//
// One byte per cycle while out_ch does not stall: each accepted byte updates
// the parser state and loads the result register in the same cycle.
// The result register is the only buffer; in_ch.ready is high while it is
// empty or being drained, so a stalled out_ch stalls the input.
// Synchronous active-low reset clears the parser state and sets
// name_limit to 255.
`default_nettype none

module control_packet_tlv_parser_unit
  import cptp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  cptp_in_if.sink         in_ch,
  cptp_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic [7:0]  name_limit_r;

  phase_t      phase_r, phase_nxt, phase_upd;
  kind_t       kind_r, kind_nxt, kind_upd;
  logic [7:0]  left_r, left_nxt, left_upd;
  logic [63:0] accum_r, accum_nxt, accum_upd;
  logic        seen_r, seen_nxt, seen_upd;
  logic [7:0]  count_r, count_nxt, count_upd;
  logic [7:0]  keep_r, keep_nxt, keep_upd;
  status_t     err_r, err_nxt, err_upd;

  logic        accept;
  logic        nv;
  status_t     st;
  logic [63:0] fs;
  logic [7:0]  nl;

  logic        out_valid_r;
  logic        name_valid_r;
  logic [7:0]  name_index_r;
  logic [7:0]  name_char_r;
  logic        packet_done_r;
  logic [63:0] file_size_r;
  logic [7:0]  name_length_r;
  status_t     parse_status_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r <= NAME_LIMIT_RST;
    end else if (cfg_we) begin
      name_limit_r <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    phase_upd = phase_r;
    kind_upd  = kind_r;
    left_upd  = left_r;
    accum_upd = accum_r;
    seen_upd  = seen_r;
    count_upd = count_r;
    keep_upd  = keep_r;
    err_upd   = err_r;
    if (err_r == ST_OK) begin
      case (phase_r)
        PH_CONTROL: begin
          phase_upd = PH_TYPE;
        end
        PH_TYPE: begin
          if (in_ch.packet_byte == TYPE_SIZE) begin
            kind_upd = KIND_SIZE;
          end else if (in_ch.packet_byte == TYPE_NAME) begin
            kind_upd = KIND_NAME;
          end else begin
            kind_upd = KIND_OTHER;
          end
          phase_upd = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (kind_r == KIND_SIZE &&
              (in_ch.packet_byte == 8'd0 || in_ch.packet_byte > SIZE_MAX_BYTES)) begin
            err_upd = ST_BADLEN;
          end else begin
            if (kind_r == KIND_SIZE) begin
              accum_upd = '0;
            end else if (kind_r == KIND_NAME) begin
              if (in_ch.packet_byte == 8'd0) begin
                count_upd = '0;
                keep_upd  = '0;
              end else if (name_limit_r != 8'd0) begin
                count_upd = '0;
                keep_upd  = (in_ch.packet_byte < name_limit_r) ? in_ch.packet_byte
                                                                : name_limit_r;
              end else begin
                keep_upd = '0;
              end
            end
            left_upd  = in_ch.packet_byte;
            phase_upd = (in_ch.packet_byte == 8'd0) ? PH_TYPE : PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (kind_r == KIND_SIZE) begin
            accum_upd = {accum_r[55:0], in_ch.packet_byte};
          end else if (kind_r == KIND_NAME && keep_r != 8'd0) begin
            count_upd = count_r + 8'd1;
            keep_upd  = keep_r - 8'd1;
          end
          left_upd = left_r - 8'd1;
          if (left_r == 8'd1) begin
            if (kind_r == KIND_SIZE) begin
              seen_upd = 1'b1;
            end
            phase_upd = PH_TYPE;
          end
        end
        default: begin
          phase_upd = phase_r;
        end
      endcase
    end

    if (in_ch.is_last) begin
      phase_nxt = PH_CONTROL;
      kind_nxt  = KIND_SIZE;
      left_nxt  = '0;
      accum_nxt = '0;
      seen_nxt  = 1'b0;
      count_nxt = '0;
      keep_nxt  = '0;
      err_nxt   = ST_OK;
    end else begin
      phase_nxt = phase_upd;
      kind_nxt  = kind_upd;
      left_nxt  = left_upd;
      accum_nxt = accum_upd;
      seen_nxt  = seen_upd;
      count_nxt = count_upd;
      keep_nxt  = keep_upd;
      err_nxt   = err_upd;
    end
  end

  // result
  always_comb begin
    nv = (err_r == ST_OK) && (phase_r == PH_VALUE) && (kind_r == KIND_NAME) &&
         (keep_r != 8'd0);
    st = ST_OK;
    fs = '0;
    nl = '0;
    if (in_ch.is_last) begin
      if (err_upd != ST_OK) begin
        st = err_upd;
      end else if (phase_upd == PH_VALUE) begin
        st = ST_TRUNC;
      end else if (!seen_upd) begin
        st = ST_NOSIZE;
      end else begin
        st = ST_OK;
      end
      fs = (st == ST_OK) ? accum_upd : '0;
      nl = count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CONTROL;
      kind_r  <= KIND_SIZE;
      left_r  <= '0;
      accum_r <= '0;
      seen_r  <= 1'b0;
      count_r <= '0;
      keep_r  <= '0;
      err_r   <= ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      left_r  <= left_nxt;
      accum_r <= accum_nxt;
      seen_r  <= seen_nxt;
      count_r <= count_nxt;
      keep_r  <= keep_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_valid_r   <= nv;
      name_index_r   <= nv ? count_r : 8'd0;
      name_char_r    <= nv ? in_ch.packet_byte : 8'd0;
      packet_done_r  <= in_ch.is_last;
      file_size_r    <= fs;
      name_length_r  <= nl;
      parse_status_r <= st;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.name_valid   = name_valid_r;
  assign out_ch.name_index   = name_index_r;
  assign out_ch.name_char    = name_char_r;
  assign out_ch.packet_done  = packet_done_r;
  assign out_ch.file_size    = file_size_r;
  assign out_ch.name_length  = name_length_r;
  assign out_ch.parse_status = parse_status_r;

  // last byte rearms the parser
  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.is_last |=> phase_r == PH_CONTROL && err_r == ST_OK && !seen_r)
    else $error("parser not rearmed after last byte");

  // an error holds until the packet ends
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.is_last && err_r != ST_OK |=> err_r == $past(err_r))
    else $error("error code changed inside packet");

  // no name output once an error is set
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && err_r != ST_OK |=> !name_valid_r)
    else $error("name byte emitted after error");

  // mid-packet results carry no summary
  a_mid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !packet_done_r |->
      parse_status_r == ST_OK && file_size_r == 64'd0 && name_length_r == 8'd0)
    else $error("summary fields set on mid-packet result");

  // size only reported with ok status
  a_size_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && parse_status_r != ST_OK |-> file_size_r == 64'd0)
    else $error("file size reported with error status");

endmodule

`default_nettype wire
